// ===== hdl/cpe_pkg.sv =====
// ----------------------------------------------------------------------------
// cpe_pkg: shared types and constants for the Chebyshev evaluator
// Beat format handed from cell to cell and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

  localparam int unsigned ORD_W  = 4;
  localparam int unsigned X_W    = 16;
  localparam int unsigned ACC_W  = 34;
  localparam int unsigned PROD_W = X_W + ACC_W;
  localparam int unsigned FRAC_SHIFT = 15;

  localparam logic signed [ACC_W-1:0] ONE_Q230 = ACC_W'(64'sd1 <<< 30);
  localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(64'sd1 <<< 14);
  localparam logic signed [PROD_W-1:0] HALF_PROD = PROD_W'(64'sd1 <<< 14);

  localparam logic signed [X_W-1:0] RES_MAX = 16'sh7fff;
  localparam logic signed [X_W-1:0] RES_MIN = 16'sh8000;

  typedef struct packed {
    logic                    valid;
    logic                    err;
    logic [ORD_W-1:0]        order;
    logic signed [X_W-1:0]   x;
    logic signed [ACC_W-1:0] prev;
    logic signed [ACC_W-1:0] cur;
  } cpe_beat_t;

endpackage

`default_nettype wire

// ===== hdl/cpe_cell.sv =====
// ----------------------------------------------------------------------------
// cpe_cell: one recurrence step
// Applies T(k+1) = 2*round(x*T(k)) - T(k-1) when the order calls for it,
// otherwise passes the beat on unchanged. Registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_cell
  import cpe_pkg::*;
#(
  parameter int unsigned STEP = 1
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cpe_beat_t  beat_i,
  output cpe_beat_t  beat_o
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]  p_val;
  logic signed [ACC_W-1:0]  next_val;
  logic                     do_step;
  cpe_beat_t                beat_d;
  cpe_beat_t                beat_q;

  assign prod     = PROD_W'(beat_i.x) * PROD_W'(beat_i.cur);
  assign prod_rnd = prod + HALF_PROD;
  assign p_val    = prod_rnd[FRAC_SHIFT +: ACC_W];
  assign next_val = {p_val[ACC_W-2:0], 1'b0} - beat_i.prev;
  assign do_step  = ({1'b0, beat_i.order} > (ORD_W + 1)'(STEP));

  always_comb begin
    beat_d = beat_i;
    if (do_step) begin
      beat_d.prev = beat_i.cur;
      beat_d.cur  = next_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

`default_nettype wire

// ===== hdl/chebyshev_poly_eval.sv =====
// ----------------------------------------------------------------------------
// chebyshev_poly_eval: Chebyshev polynomial of the first kind, T_order(x)
// Q1.15 argument, Q4.30 recurrence through a row of step cells, Q1.15
// rounded and saturated result; orders above MAX_ORDER flag an error.
// ----------------------------------------------------------------------------
// Pipeline from start_i to done_o: one input register, MAX_ORDER-1 step
//   cells and one output register.
// Throughput: one beat per cycle; busy_o is never raised.
// The receiver cannot stall; done_o marks each result for one cycle.
// Reset clears the valid bits of every stage; no beat is in flight after it.
`default_nettype none

module chebyshev_poly_eval
  import cpe_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 10
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire  [ORD_W-1:0]      order_i,
  input  wire  signed [X_W-1:0] x_value_i,
  output logic                  done_o,
  output logic signed [X_W-1:0] result_value_o,
  output logic                  order_error_o
);

  cpe_beat_t chain [MAX_ORDER];
  cpe_beat_t in_d;
  cpe_beat_t in_q;

  logic signed [ACC_W-1:0]            fin_rnd;
  logic signed [ACC_W-FRAC_SHIFT-1:0] fin_val;
  logic signed [X_W-1:0]              res_d;
  logic signed [X_W-1:0]              res_q;
  logic                               err_q;
  logic                               done_q;

  assign busy_o = 1'b0;

  always_comb begin
    in_d.valid = start_i;
    in_d.err   = ({1'b0, order_i} > (ORD_W + 1)'(MAX_ORDER));
    in_d.order = order_i;
    in_d.x     = x_value_i;
    in_d.prev  = ONE_Q230;
    in_d.cur   = (order_i == '0) ? ONE_Q230
                                 : {{(ACC_W-X_W-FRAC_SHIFT){x_value_i[X_W-1]}},
                                    x_value_i, {FRAC_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else begin
      in_q <= in_d;
    end
  end

  assign chain[0] = in_q;

  for (genvar g = 1; g < MAX_ORDER; g++) begin : g_cell
    cpe_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (chain[g-1]),
      .beat_o (chain[g])
    );
  end

  assign fin_rnd = chain[MAX_ORDER-1].cur + HALF_ACC;
  assign fin_val = fin_rnd[ACC_W-1:FRAC_SHIFT];

  always_comb begin
    if (chain[MAX_ORDER-1].err) begin
      res_d = '0;
    end else if (fin_val > (ACC_W-FRAC_SHIFT)'(signed'(RES_MAX))) begin
      res_d = RES_MAX;
    end else if (fin_val < (ACC_W-FRAC_SHIFT)'(signed'(RES_MIN))) begin
      res_d = RES_MIN;
    end else begin
      res_d = fin_val[X_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[MAX_ORDER-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    err_q <= chain[MAX_ORDER-1].err;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign order_error_o  = err_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && order_error_o) |-> (result_value_o == '0))
    else $error("order error beat carries a non-zero value");

  a_pipe_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[0].valid |-> ##(MAX_ORDER) done_o)
    else $error("accepted beat did not reach the output");

  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[0].valid |-> (chain[0].err == (chain[0].order > ORD_W'(MAX_ORDER))
                        || MAX_ORDER > 15))
    else $error("error flag does not match order");

endmodule

`default_nettype wire

// ===== sim/chebyshev_poly_eval_tb.sv =====
// ----------------------------------------------------------------------------
// chebyshev_poly_eval_tb: self-checking bench for the Chebyshev evaluator
// Directed edge cases, then random beats in four phases (two with idle gaps).
// Results are checked against typed table values or a fixed-point model of
// the Q4.30 recurrence. Orders above the maximum must raise the error flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chebyshev_poly_eval_tb;
  import cpe_pkg::*;

  localparam int unsigned MAX_ORD    = 10;
  localparam int          PHASE_LEN  = 475;
  localparam int          STALL_LIM  = 2000;
  localparam logic        ORDER_OK   = 1'b0;
  localparam logic        ORDER_BAD  = 1'b1;
  localparam int          N_DIRECTED = 22;

  typedef struct packed {
    logic signed [X_W-1:0] value;
    logic                  err;
  } cheb_res_t;

  typedef struct packed {
    logic [ORD_W-1:0]      order;
    logic signed [X_W-1:0] x;
    bit                    typed;
    logic signed [X_W-1:0] value;
    logic                  err;
  } cheb_vec_t;

  // typed = 0: the value comes from the model below
  localparam cheb_vec_t DIRECTED [N_DIRECTED] = '{
    '{4'd0,  16'sd0,      1'b1, RES_MAX,   ORDER_OK},
    '{4'd0,  RES_MIN,     1'b1, RES_MAX,   ORDER_OK},
    '{4'd0,  RES_MAX,     1'b1, RES_MAX,   ORDER_OK},
    '{4'd1,  RES_MAX,     1'b1, RES_MAX,   ORDER_OK},
    '{4'd1,  RES_MIN,     1'b1, RES_MIN,   ORDER_OK},
    '{4'd1,  16'sd12345,  1'b1, 16'sd12345, ORDER_OK},
    '{4'd2,  RES_MIN,     1'b1, RES_MAX,   ORDER_OK},
    '{4'd3,  RES_MIN,     1'b1, RES_MIN,   ORDER_OK},
    '{4'd10, RES_MIN,     1'b1, RES_MAX,   ORDER_OK},
    '{4'd2,  16'sd0,      1'b1, RES_MIN,   ORDER_OK},
    '{4'd3,  16'sd0,      1'b1, 16'sd0,    ORDER_OK},
    '{4'd11, 16'sd1000,   1'b1, 16'sd0,    ORDER_BAD},
    '{4'd15, RES_MIN,     1'b1, 16'sd0,    ORDER_BAD},
    '{4'd15, RES_MAX,     1'b1, 16'sd0,    ORDER_BAD},
    '{4'd4,  RES_MAX,     1'b0, 16'sd0,    ORDER_OK},
    '{4'd5,  16'sd16384,  1'b0, 16'sd0,    ORDER_OK},
    '{4'd6,  16'sd23170,  1'b0, 16'sd0,    ORDER_OK},
    '{4'd7,  -16'sd1,     1'b0, 16'sd0,    ORDER_OK},
    '{4'd8,  16'sd30000,  1'b0, 16'sd0,    ORDER_OK},
    '{4'd9,  16'sd1,      1'b0, 16'sd0,    ORDER_OK},
    '{4'd10, -16'sd20000, 1'b0, 16'sd0,    ORDER_OK},
    '{4'd10, RES_MAX,     1'b0, 16'sd0,    ORDER_OK}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [ORD_W-1:0]      order_i;
  logic signed [X_W-1:0] x_value_i;
  logic                  done_o;
  logic signed [X_W-1:0] result_value_o;
  logic                  order_error_o;

  cheb_res_t pending_q [$];
  int        fail_cnt;
  int        stall_cycles = 0;

  chebyshev_poly_eval #(
    .MAX_ORDER(MAX_ORD)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .order_i       (order_i),
    .x_value_i     (x_value_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .order_error_o (order_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // T_order(x): Q4.30 recurrence, products rounded half up, Q1.15 out
  function automatic cheb_res_t cheb_t(input logic [ORD_W-1:0] ord,
                                       input logic signed [X_W-1:0] xv);
    cheb_res_t   r;
    longint      xl;
    longint      t_prev;
    longint      t_cur;
    longint      t_next;
    longint      prod;
    longint      q;
    r.err   = ORDER_OK;
    r.value = '0;
    if (ord > MAX_ORD) begin
      r.err = ORDER_BAD;
      return r;
    end
    xl     = longint'(xv);
    t_prev = longint'(1) <<< 30;
    t_cur  = xl * 32768;
    if (ord == 0) begin
      t_cur = t_prev;
    end else begin
      for (int k = 1; k < ord; k++) begin
        prod   = (xl * t_cur + (longint'(1) <<< 14)) >>> FRAC_SHIFT;
        t_next = 2 * prod - t_prev;
        t_prev = t_cur;
        t_cur  = t_next;
      end
    end
    q = (t_cur + (longint'(1) <<< 14)) >>> FRAC_SHIFT;
    if (q > 32767) begin
      q = 32767;
    end
    if (q < -32768) begin
      q = -32768;
    end
    r.value = X_W'(q);
    return r;
  endfunction

  function automatic logic [ORD_W-1:0] rand_order();
    if ($urandom_range(0, 99) < 12) begin
      return ORD_W'($urandom_range(MAX_ORD + 1, 15));
    end
    return ORD_W'($urandom_range(0, MAX_ORD));
  endfunction

  function automatic logic signed [X_W-1:0] rand_x();
    case ($urandom_range(0, 9))
      0: return RES_MIN;
      1: return RES_MAX;
      2: return X_W'(int'($urandom_range(0, 128)) - 64);
      3: return RES_MIN + X_W'($urandom_range(0, 64));
      4: return RES_MAX - X_W'($urandom_range(0, 64));
      default: return X_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [ORD_W-1:0] ord, input logic signed [X_W-1:0] xv,
                           input bit typed, input cheb_res_t typed_res);
    cheb_res_t want;
    want = typed ? typed_res : cheb_t(ord, xv);
    start_i   <= 1'b1;
    order_i   <= ord;
    x_value_i <= xv;
    do @(posedge clk_i); while (busy_o);
    pending_q.push_back(want);
  endtask

  task automatic sender_gap(input int pct);
    int n;
    if ($urandom_range(0, 99) < pct) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3);
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    int        idle_pct [4];
    cheb_res_t typed_res;
    idle_pct  = '{0, 55, 0, 24};
    fail_cnt  = 0;
    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    order_i   <= '0;
    x_value_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_res.value = DIRECTED[i].value;
      typed_res.err   = DIRECTED[i].err;
      send_beat(DIRECTED[i].order, DIRECTED[i].x, DIRECTED[i].typed, typed_res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < PHASE_LEN; n++) begin
        sender_gap(idle_pct[ph]);
        send_beat(rand_order(), rand_x(), 1'b0, '0);
      end
    end
    start_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (MAX_ORD + 5) @(posedge clk_i);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk_i) begin : result_chk
    cheb_res_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: result_value %0d order_error %0b",
               $signed(result_value_o), order_error_o);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (result_value_o !== want.value) begin
          $error("result_value: expected %0d, got %0d",
                 $signed(want.value), $signed(result_value_o));
          fail_cnt++;
        end
        if (order_error_o !== want.err) begin
          $error("order_error: expected %0b, got %0b", want.err, order_error_o);
          fail_cnt++;
        end
      end
    end
  end

  // no beat in or out for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIM) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
hdl/cpe_pkg.sv
hdl/cpe_cell.sv
hdl/chebyshev_poly_eval.sv
sim/chebyshev_poly_eval_tb.sv
